[hw/rtl/cdrr_pkg.sv]
// shared types, constants and the answer record table for the dns reply rewriter
// no dependencies
package cdrr_pkg;

   localparam int unsigned MAX_PACKET_BYTES_DEF = 512;
   localparam int unsigned POS_W = 16;
   localparam int unsigned HDR_LEN = 12;
   localparam int unsigned ANS_LEN = 16;
   localparam int unsigned CNT_W = $clog2(ANS_LEN + 1);
   localparam int unsigned ANS_IDX_W = $clog2(ANS_LEN);

   // header rewrite values
   localparam logic [7:0] FLAGS_HI = 8'h81;
   localparam logic [7:0] FLAGS_LO = 8'h80;
   localparam logic [7:0] ANCOUNT_HI = 8'h00;
   localparam logic [7:0] ANCOUNT_LO = 8'h01;

   // answer record constants
   localparam logic [7:0] PTR_HI = 8'hC0;
   localparam logic [7:0] PTR_LO = 8'h0C;
   localparam logic [7:0] TYPE_A = 8'h01;
   localparam logic [7:0] CLASS_IN = 8'h01;
   localparam logic [7:0] TTL_SECS = 8'd60;
   localparam logic [7:0] RDLEN_V4 = 8'h04;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       discard;
   } rsp_type;

   // per-beat outcome of the parser, held by the emitter
   typedef struct packed {
      logic       echo;
      logic [7:0] echo_byte;
      logic       last;
      logic       bad;
   } item_type;

   function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                              input logic [31:0] ip);
      logic [7:0] res;
      begin
         case (idx)
            4'd0: res = PTR_HI;
            4'd1: res = PTR_LO;
            4'd3: res = TYPE_A;
            4'd5: res = CLASS_IN;
            4'd9: res = TTL_SECS;
            4'd11: res = RDLEN_V4;
            4'd12: res = ip[31:24];
            4'd13: res = ip[23:16];
            4'd14: res = ip[15:8];
            4'd15: res = ip[7:0];
            default: res = 8'h00;
         endcase
         answer_byte = res;
      end
   endfunction

endpackage

[hw/rtl/cdrr_parser.sv]
// per-beat query parser: walks header, qname labels and type/class bytes
// depends on cdrr_pkg
module cdrr_parser
   import cdrr_pkg::*;
#(
   parameter int unsigned MaxPacketBytes = MAX_PACKET_BYTES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     beat_fire,
   input  req_type  beat,
   output item_type item,
   output logic     item_keep
);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_QNAME = 2'd1;
   localparam logic [1:0] PH_TAIL4 = 2'd2;
   localparam logic [1:0] PH_DROP = 2'd3;
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MaxPacketBytes);
   localparam logic [POS_W:0] SAT_MAX = {1'b0, {POS_W{1'b1}}};

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] next_label_ff, next_label_in;
   logic [POS_W-1:0] qend_ff, qend_in;
   logic [1:0]       phase_ff, phase_in;
   logic             overlong;
   logic             echo;
   logic [7:0]       eb;
   logic [POS_W:0]   label_sum;
   logic [POS_W:0]   qend_sum;
   logic [POS_W:0]   pos_inc;

   assign overlong = (pos_ff >= MAX_POS);
   assign pos_inc = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign label_sum = {1'b0, pos_ff} + (POS_W+1)'(beat.data_byte) + (POS_W+1)'(1);
   assign qend_sum = {1'b0, pos_ff} + (POS_W+1)'(5);

   always_comb begin
      echo = 1'b0;
      eb = beat.data_byte;
      phase_in = phase_ff;
      next_label_in = next_label_ff;
      qend_in = qend_ff;
      pos_in = pos_ff;
      if (!overlong) begin
         pos_in = pos_inc[POS_W-1:0];
         case (phase_ff)
            PH_HEADER: begin
               echo = 1'b1;
               if (pos_ff == POS_W'(2)) eb = FLAGS_HI;
               else if (pos_ff == POS_W'(3)) eb = FLAGS_LO;
               else if (pos_ff == POS_W'(6)) eb = ANCOUNT_HI;
               else if (pos_ff == POS_W'(7)) eb = ANCOUNT_LO;
               if (pos_inc >= (POS_W+1)'(HDR_LEN)) phase_in = PH_QNAME;
            end
            PH_QNAME: begin
               echo = 1'b1;
               if (pos_ff == next_label_ff) begin
                  if (beat.data_byte == 8'h00) begin
                     qend_in = (qend_sum > SAT_MAX) ? SAT_MAX[POS_W-1:0]
                                                    : qend_sum[POS_W-1:0];
                     phase_in = PH_TAIL4;
                  end else begin
                     next_label_in = (label_sum > SAT_MAX) ? SAT_MAX[POS_W-1:0]
                                                           : label_sum[POS_W-1:0];
                  end
               end
            end
            PH_TAIL4: begin
               echo = 1'b1;
               if (pos_inc >= {1'b0, qend_ff}) phase_in = PH_DROP;
            end
            default: begin
            end
         endcase
      end
   end

   assign item.echo = echo;
   assign item.echo_byte = eb;
   assign item.last = beat.last_byte;
   assign item.bad = overlong || (phase_in != PH_DROP);
   assign item_keep = echo || beat.last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         next_label_ff <= POS_W'(HDR_LEN);
         qend_ff <= '0;
         phase_ff <= PH_HEADER;
      end else if (beat_fire) begin
         if (beat.last_byte) begin
            pos_ff <= '0;
            next_label_ff <= POS_W'(HDR_LEN);
            qend_ff <= '0;
            phase_ff <= PH_HEADER;
         end else begin
            pos_ff <= pos_in;
            next_label_ff <= next_label_in;
            qend_ff <= qend_in;
            phase_ff <= phase_in;
         end
      end
   end

endmodule

[hw/rtl/cdrr_emitter.sv]
// result sequencer: holds one parsed beat and plays out its echo, answer or discard beats
// depends on cdrr_pkg
module cdrr_emitter
   import cdrr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  item_type    item,
   input  logic [31:0] answer_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   output logic        req_stall
);

   logic             valid_ff;
   item_type         item_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] ans_pos;
   logic             final_beat;
   logic             fire;

   // cnt 0 is the echo byte, 1..16 are the answer bytes
   assign ans_pos = cnt_ff - CNT_W'(1);
   assign fire = valid_ff && !rsp_stall;

   always_comb begin
      rsp_data.discard = 1'b0;
      rsp_data.frame_end = 1'b0;
      final_beat = 1'b0;
      if (item_ff.last && item_ff.bad) begin
         rsp_data.out_byte = 8'h00;
         rsp_data.frame_end = 1'b1;
         rsp_data.discard = 1'b1;
         final_beat = 1'b1;
      end else if (cnt_ff == '0) begin
         rsp_data.out_byte = item_ff.echo_byte;
         final_beat = !item_ff.last;
      end else begin
         rsp_data.out_byte = answer_byte(ans_pos[ANS_IDX_W-1:0], answer_addr);
         rsp_data.frame_end = (cnt_ff == CNT_W'(ANS_LEN));
         final_beat = rsp_data.frame_end;
      end
   end

   assign rsp_valid = valid_ff;
   assign req_stall = valid_ff && !(fire && final_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         cnt_ff <= item.echo ? CNT_W'(0) : CNT_W'(1);
      end else if (fire) begin
         if (final_beat) valid_ff <= 1'b0;
         else cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) item_ff <= item;
   end

endmodule

[hw/rtl/captive_dns_reply_rewriter.sv]
// captive dns reply rewriter top level; uses cdrr_pkg, cdrr_parser and cdrr_emitter
// reply: the first reply beat is offered in the cycle after its query byte is taken (one result register)
// throughput: one query byte per cycle while bytes are echoed or dropped and the reply side
//   does not stall; the answer record of a good query plays out of the same register, so the
//   byte after it is taken together with the final answer beat
// reset: synchronous, active high; header phase, nothing pending, answer address zero
module captive_dns_reply_rewriter
   import cdrr_pkg::*;
#(
   parameter int unsigned MaxPacketBytes = MAX_PACKET_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // query byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // reply byte channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // captive address register
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic        addr_loaded_ff;
   logic [31:0] answer_addr_ff;
   logic        req_fire;
   item_type    item;
   logic        item_keep;

   // address returned in every answer, host order; to be written only while idle, which the block does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         answer_addr_ff <= '0;
         addr_loaded_ff <= 1'b0;
      end else if (csr_wr_en) begin
         answer_addr_ff <= csr_wr_data;
         addr_loaded_ff <= 1'b1;
      end
   end

   assign req_fire = req_valid && !req_stall;

   // parser updates its position state on every taken beat and classifies it
   cdrr_parser #(
      .MaxPacketBytes(MaxPacketBytes)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .beat_fire(req_fire),
      .beat     (req_data),
      .item     (item),
      .item_keep(item_keep)
   );

   // beats with nothing to send (dropped trailing bytes) never occupy the emitter
   cdrr_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load       (req_fire && item_keep),
      .item       (item),
      .answer_addr(answer_addr_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .req_stall  (req_stall)
   );

   // a discard marker always closes its reply
   a_discard_ends : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.discard |-> rsp_data.frame_end)
      else $error("discard beat without frame_end");

   // handing over the last beat of a reply frees the input at once
   a_end_frees_input : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.frame_end |-> !req_stall)
      else $error("input still stalled after final reply beat");

   // the input only waits while a result beat is on offer
   a_stall_needs_pending : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with nothing pending");

   // after a write the register has been loaded at least once
   a_csr_loaded : assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> addr_loaded_ff && (answer_addr_ff == $past(csr_wr_data)))
      else $error("captive address not taken");

endmodule

[tb/sv/tb_captive_dns_reply_rewriter.sv]
// self-checking testbench for the captive dns reply rewriter: query bytes in, reply bytes out
// depends on cdrr_pkg for the beat structs, header length, packet limit and answer constants
`timescale 1ns / 1ps

module tb_captive_dns_reply_rewriter
   import cdrr_pkg::*;
();

   localparam int QUIET_LIMIT = 3000;          // cycles with no beat on either side
   localparam int HOLD_OFF_CYCLES = 240;       // long receiver hold-off
   localparam int SETTLE_CYCLES = 8;           // pause after the last expected beat
   localparam int RANDOM_BYTES_PER_PHASE = 12;

   // where the parser is within the query
   typedef enum logic [1:0] {
      PH_HEADER,
      PH_QNAME,
      PH_TYPE_CLASS,
      PH_TRAILER
   } query_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // traffic shaping
   int   tx_idle_pct = 0;
   int   rx_stall_pct = 0;
   logic hold_req = 1'b0;
   int   hold_left = 0;

   // reply predictor state
   int unsigned     q_pos;
   int unsigned     q_label_at;
   int unsigned     q_question_end;
   query_phase_type q_phase;
   logic [31:0]     q_answer_addr;

   rsp_type    reply_q[$];     // reply beats still owed by the block
   logic [7:0] pkt_buf[$];     // query being built for sending
   int         fault_count = 0;
   int         quiet_cycles = 0;

   captive_dns_reply_rewriter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- reply predictor

   function automatic int unsigned sat16(input int unsigned v);
      return (v > 32'hFFFF) ? 32'hFFFF : v;
   endfunction

   task automatic restart_query;
      q_pos = 0;
      q_label_at = HDR_LEN;
      q_question_end = 0;
      q_phase = PH_HEADER;
   endtask

   task automatic push_beat(input logic [7:0] b, input logic fe, input logic disc);
      rsp_type r;
      r.out_byte = b;
      r.frame_end = fe;
      r.discard = disc;
      reply_q.push_back(r);
   endtask

   // works out the reply beats owed for one accepted query byte
   task automatic predict_reply(input logic [7:0] b, input logic last);
      int unsigned  pos;
      bit           overlong;
      bit           echo;
      logic [7:0]   eb;
      logic [127:0] answer;
      int           i;
      pos = q_pos;
      overlong = (pos >= MAX_PACKET_BYTES_DEF);
      echo = 1'b0;
      eb = b;
      if (!overlong) begin
         case (q_phase)
            PH_HEADER: begin
               echo = 1'b1;
               // flags forced to a recursive answer, ancount forced to one
               if (pos == 2) eb = FLAGS_HI;
               else if (pos == 3) eb = FLAGS_LO;
               else if (pos == 6) eb = ANCOUNT_HI;
               else if (pos == 7) eb = ANCOUNT_LO;
               if (pos + 1 >= HDR_LEN) q_phase = PH_QNAME;
            end
            PH_QNAME: begin
               echo = 1'b1;
               // only bytes at a label boundary steer the walk
               if (pos == q_label_at) begin
                  if (b == 8'h00) begin
                     q_question_end = sat16(pos + 5);
                     q_phase = PH_TYPE_CLASS;
                  end else begin
                     q_label_at = sat16(pos + b + 1);
                  end
               end
            end
            PH_TYPE_CLASS: begin
               echo = 1'b1;
               if (pos + 1 >= q_question_end) q_phase = PH_TRAILER;
            end
            default: begin
            end
         endcase
         q_pos = pos + 1;
      end

      if (!last) begin
         if (echo) push_beat(eb, 1'b0, 1'b0);
      end else if (overlong || q_phase != PH_TRAILER) begin
         // short, truncated or over-long query: single discard marker
         push_beat(8'h00, 1'b1, 1'b1);
         restart_query();
      end else begin
         if (echo) push_beat(eb, 1'b0, 1'b0);
         answer = {PTR_HI, PTR_LO, 8'h00, TYPE_A, 8'h00, CLASS_IN, 24'h000000, TTL_SECS,
                   8'h00, RDLEN_V4, q_answer_addr};
         for (i = 0; i < 16; i++)
            push_beat(answer[127 - 8 * i -: 8], (i == 15), 1'b0);
         restart_query();
      end
   endtask

   // ---------------------------------------------------------------- receiver and checker

   // receiver stall: long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_OFF_CYCLES;
      end else begin
         rsp_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
      end
   end

   // every accepted reply beat against the oldest one owed
   always @(posedge clock) begin : check_beat
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reply_q.size() == 0) begin
            $error("unexpected reply beat: out_byte %h frame_end %b discard %b",
                   rsp_data.out_byte, rsp_data.frame_end, rsp_data.discard);
            fault_count++;
         end else begin
            want = reply_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
               fault_count++;
            end
            if (rsp_data.frame_end !== want.frame_end) begin
               $error("frame_end: expected %b, got %b", want.frame_end, rsp_data.frame_end);
               fault_count++;
            end
            if (rsp_data.discard !== want.discard) begin
               $error("discard: expected %b, got %b", want.discard, rsp_data.discard);
               fault_count++;
            end
         end
      end
   end

   // watchdog: too long with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sender side

   // offers one query byte, holds it until taken, then predicts its reply
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {b, last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_reply(b, last);
   endtask

   task automatic send_query;
      int i;
      for (i = 0; i < pkt_buf.size(); i++)
         send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
   endtask

   // well-formed query with random content: header, labels, root label, type and class, optional trailing bytes
   task automatic make_query(input int n_labels, input int min_len, input int max_len,
                             input int trailing);
      int len;
      pkt_buf.delete();
      repeat (HDR_LEN) pkt_buf.push_back(8'($urandom_range(255)));
      repeat (n_labels) begin
         len = $urandom_range(max_len, min_len);
         pkt_buf.push_back(8'(len));
         repeat (len) pkt_buf.push_back(8'($urandom_range(255)));
      end
      pkt_buf.push_back(8'h00);
      repeat (4) pkt_buf.push_back(8'($urandom_range(255)));
      repeat (trailing) pkt_buf.push_back(8'($urandom_range(255)));
   endtask

   task automatic make_noise(input int n);
      pkt_buf.delete();
      repeat (n) pkt_buf.push_back(8'($urandom_range(255)));
   endtask

   // drop valid and wait for every owed beat, plus a short settle
   task automatic drain;
      req_valid <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_answer_addr(input logic [31:0] ip);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= ip;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      q_answer_addr = ip;
   endtask

   // ---------------------------------------------------------------- tests

   // address register still at its reset value
   task automatic test_reset_address;
      make_query(1, 1, 3, 0);
      send_query();
      drain();
   endtask

   // header bytes at both extremes, first with one short label, then with a root-only name
   task automatic test_header_extremes;
      int i;
      make_query(1, 1, 2, 0);
      for (i = 0; i < HDR_LEN; i++) pkt_buf[i] = 8'hFF;
      send_query();
      make_query(0, 1, 1, 0);
      for (i = 0; i < HDR_LEN; i++) pkt_buf[i] = 8'h00;
      send_query();
      drain();
   endtask

   // many tiny labels, then one longer label
   task automatic test_label_walk;
      make_query(4, 1, 1, 0);
      send_query();
      make_query(1, 12, 12, 0);
      send_query();
      drain();
   endtask

   // bytes after the question are dropped, answer still follows
   task automatic test_trailing_bytes;
      make_query(1, 1, 3, 4);
      send_query();
      drain();
   endtask

   // short packets and questions that stop early
   task automatic test_short_and_truncated;
      make_noise(1);
      send_query();
      make_noise(HDR_LEN - 1);
      send_query();
      make_noise(HDR_LEN);          // header only
      send_query();
      make_query(1, 3, 3, 0);       // ends on the root label
      repeat (4) void'(pkt_buf.pop_back());
      send_query();
      make_query(1, 3, 3, 0);       // one type/class byte short
      void'(pkt_buf.pop_back());
      send_query();
      make_query(0, 1, 1, 0);
      pkt_buf[HDR_LEN] = 8'hC8;     // label length runs past the end
      send_query();
      drain();
   endtask

   // answer address at its top value and with both end bits set
   task automatic test_address_sweep;
      set_answer_addr(32'hFFFF_FFFF);
      make_query(0, 1, 1, 0);
      send_query();
      set_answer_addr(32'h8000_0001);
      make_query(0, 1, 1, 2);
      send_query();
      drain();
   endtask

   // receiver holds off long while the sender keeps offering bytes
   task automatic test_backpressure;
      set_answer_addr($urandom);
      tx_idle_pct = 0;
      rx_stall_pct <= 0;
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      make_query(1, 2, 4, 2);
      send_query();
      drain();
   endtask

   // mostly good queries with random content, some broken ones and noise
   task automatic random_phase(input int tx_pct, input int rx_pct);
      int sent;
      int k;
      set_answer_addr($urandom);
      tx_idle_pct = tx_pct;
      rx_stall_pct <= rx_pct;
      sent = 0;
      while (sent < RANDOM_BYTES_PER_PHASE) begin
         k = $urandom_range(99);
         if (k < 70) begin
            make_query($urandom_range(3), 1, ($urandom_range(9) == 0) ? 63 : 8,
                       ($urandom_range(2) == 0) ? $urandom_range(4, 1) : 0);
         end else if (k < 82) begin
            make_query($urandom_range(3), 1, 8, 0);
            repeat ($urandom_range(pkt_buf.size() - 1, 1)) void'(pkt_buf.pop_back());
         end else if (k < 90) begin
            make_noise($urandom_range(HDR_LEN - 1, 1));
         end else begin
            make_noise($urandom_range(40, HDR_LEN));
         end
         send_query();
         sent += pkt_buf.size();
      end
      drain();
   endtask

   task automatic test_random_traffic;
      random_phase(0, 0);
      random_phase(58, 0);
      random_phase(0, 58);
      random_phase(14, 14);
      tx_idle_pct = 0;
      rx_stall_pct <= 0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      q_answer_addr = '0;
      restart_query();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_address();
      test_header_extremes();
      test_label_walk();
      test_trailing_bytes();
      test_short_and_truncated();
      test_address_sweep();
      test_backpressure();
      test_random_traffic();
      drain();

      if (fault_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/cdrr_pkg.sv
hw/rtl/cdrr_parser.sv
hw/rtl/cdrr_emitter.sv
hw/rtl/captive_dns_reply_rewriter.sv
tb/sv/tb_captive_dns_reply_rewriter.sv
